// ===== rtl/core/cms_pkg.sv =====
// Shared types and constants for the count-min sketch core.
package cms_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
    localparam logic [31:0] BLK_ADD = 32'he6546b64;
    localparam logic [31:0] CNT_MAX = 32'hffffffff;

    localparam logic [0:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [0:0] REG_BUCKET_BITS = 1'b1;

    localparam logic KIND_INCREMENT = 1'b0;
    localparam logic KIND_QUERY     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [31:0] key_word;
        logic [2:0] word_bytes;
        logic       last_word;
    } cms_req_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== rtl/core/cms_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/core/cms_hash.sv =====
// Per-row MurmurHash3 x86_32 block mixing, two-step pipeline per word.
module cms_hash
    import cms_pkg::*;
#(
    parameter int MAX_ROWS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     mix_start,   // step 1: word latched
    input  logic [31:0]              key_word,
    input  logic [2:0]               nbytes,      // 0..4 effective
    input  logic                     restart,     // back to seeds
    output logic                     mix_done,
    output logic [MAX_ROWS-1:0][31:0] acc
);
    logic [31:0] k1_reg, k1_next;
    logic [2:0]  nb_reg;
    logic        stage_reg;
    logic [MAX_ROWS-1:0][31:0] acc_reg, acc_next;
    logic [31:0] tail, kx, k2;

    // stage 1: first scramble multiply, masked tail
    always_comb begin
        unique case (nbytes)
            3'd1:    tail = {24'd0, key_word[7:0]};
            3'd2:    tail = {16'd0, key_word[15:0]};
            3'd3:    tail = {8'd0, key_word[23:0]};
            default: tail = key_word;
        endcase
        k1_next = tail * MIX_C1;
    end

    // stage 2: second multiply and per-row update
    always_comb begin
        kx = rotl32(k1_reg, 15) * MIX_C2;
        acc_next = acc_reg;
        for (int r = 0; r < MAX_ROWS; r++) begin
            k2 = acc_reg[r] ^ kx;
            if (nb_reg == 3'd4) begin
                acc_next[r] = rotl32(k2, 13) * 32'd5 + BLK_ADD;
            end else if (nb_reg != 3'd0) begin
                acc_next[r] = k2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg <= k1_next;
        nb_reg <= nbytes;
        if (!aresetn) begin
            stage_reg <= 1'b0;
            for (int r = 0; r < MAX_ROWS; r++) acc_reg[r] <= 32'(r);
        end else begin
            stage_reg <= mix_start;
            if (restart) begin
                for (int r = 0; r < MAX_ROWS; r++) acc_reg[r] <= 32'(r);
            end else if (stage_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign mix_done = stage_reg;
    assign acc      = acc_reg;
endmodule

// ===== rtl/core/cms_update.sv =====
// Row sequencer: finalize, table read, conservative update and clear sweep.
module cms_update
    import cms_pkg::*;
#(
    parameter int MAX_ROWS        = 8,
    parameter int MAX_BUCKET_BITS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      kind,
    input  logic [MAX_ROWS-1:0][31:0] acc,
    input  logic [31:0]               key_len,
    input  logic [3:0]                rows_in_use,
    input  logic [3:0]                bucket_bits,
    output logic                      busy,
    output logic                      clearing,
    output logic                      res_valid,
    output logic [31:0]               res_estimate
);
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = RW + MAX_BUCKET_BITS;
    localparam int DEP = MAX_ROWS << MAX_BUCKET_BITS;
    localparam int CW  = $clog2(DEP + 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_FIN1  = 7'b0000100,
        ST_FIN2  = 7'b0001000,
        ST_FIN3  = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_WRITE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg;
    logic [RW:0]   row_reg;         // row counter (min pass; write pass on increment)
    logic          pass_reg;        // 0 = find min, 1 = update
    logic          kind_reg;
    logic [31:0]   h_reg, minv_reg;
    logic [MAX_ROWS-1:0][MAX_BUCKET_BITS-1:0] idx_reg;
    logic [RW:0]   rows_eff;
    logic [MAX_BUCKET_BITS-1:0] mask;
    logic [31:0]   h_sel, h_mix;
    logic [RW-1:0] row_idx;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic          last_row;

    always_comb begin
        if (rows_in_use == 4'd0) rows_eff = (RW + 1)'(1);
        else if (32'(rows_in_use) > MAX_ROWS) rows_eff = (RW + 1)'(MAX_ROWS);
        else rows_eff = (RW + 1)'(rows_in_use);
        mask = '0;
        for (int b = 0; b < MAX_BUCKET_BITS; b++) mask[b] = (32'(b) < 32'(bucket_bits));
    end

    assign row_idx  = row_reg[RW-1:0];
    assign last_row = (row_reg + 1'b1 == rows_eff);
    assign h_sel    = acc[row_idx] ^ key_len;

    // finalize pipeline from h_sel through h_reg
    always_comb begin
        unique case (state_reg)
            ST_FIN1: h_mix = (h_sel ^ (h_sel >> 16)) * FMIX_C1;
            ST_FIN2: h_mix = (h_reg ^ (h_reg >> 13)) * FMIX_C2;
            default: h_mix = h_reg ^ (h_reg >> 16);
        endcase
    end

    always_comb begin
        ram_raddr = {row_idx, h_mix[MAX_BUCKET_BITS-1:0] & mask};
        ram_we    = 1'b0;
        ram_waddr = {row_idx, idx_reg[row_idx]};
        ram_wdata = minv_reg + 32'd1;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg[AW-1:0];
            ram_wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            ram_we = pass_reg && (ram_rdata == minv_reg) && (minv_reg != CNT_MAX);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == CW'(DEP - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_FIN1;
            ST_FIN1:  state_next = ST_FIN2;
            ST_FIN2:  state_next = ST_FIN3;
            ST_FIN3:  state_next = ST_WRITE;
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: begin
                if (!last_row) state_next = pass_reg ? ST_READ : ST_FIN1;
                else if (!pass_reg && kind_reg == KIND_INCREMENT) state_next = ST_READ;
                else state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_mix;
        if (state_reg == ST_FIN3) idx_reg[row_idx] <= h_mix[MAX_BUCKET_BITS-1:0] & mask;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            row_reg   <= '0;
            pass_reg  <= 1'b0;
            kind_reg  <= 1'b0;
            minv_reg  <= CNT_MAX;
            res_valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_valid <= 1'b0;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_IDLE && start) begin
                row_reg  <= '0;
                pass_reg <= 1'b0;
                kind_reg <= kind;
                minv_reg <= CNT_MAX;
            end
            if (state_reg == ST_WRITE) begin
                if (!pass_reg && ram_rdata < minv_reg) minv_reg <= ram_rdata;
                if (!last_row) begin
                    row_reg <= row_reg + 1'b1;
                end else begin
                    row_reg  <= '0;
                    pass_reg <= 1'b1;
                    if (!pass_reg && kind_reg == KIND_QUERY) begin
                        res_valid <= 1'b1;
                        res_estimate <= (ram_rdata < minv_reg) ? ram_rdata : minv_reg;
                    end
                end
            end
        end
    end

    // in update pass, READ state re-reads the stored index
    logic [AW-1:0] rd_addr_mux;
    assign rd_addr_mux = (state_reg == ST_READ) ? {row_idx, idx_reg[row_idx]} : ram_raddr;

    cms_ram #(.WIDTH(32), .DEPTH(DEP)) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr_mux),
        .rd_data (ram_rdata)
    );

    assign busy     = (state_reg != ST_IDLE);
    assign clearing = (state_reg == ST_CLEAR);
endmodule

// ===== rtl/core/count_min_sketch_conservative_core.sv =====
// Sequencing: a non-last word passes the hash pipeline; a last word then runs
// the min pass over the used rows (finalize, table read) and, for an increment,
// an update pass (re-read, write); the hashes restart before the next word is taken.
// Input: a new word is taken only after the previous one has left the hash pipe;
// keys are sequenced one at a time and a pending result holds off new requests.
// Reset: synchronous; after reset a sweep over MAX_ROWS * 2^MAX_BUCKET_BITS cells
// clears the counter table while s_tready stays low; config writes are accepted.
module count_min_sketch_conservative_core
    import cms_pkg::*;
#(
    parameter int MAX_ROWS        = 8,
    parameter int MAX_BUCKET_BITS = 12
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // key_word[31:0], word_bytes[34:32], zero fill
    input  logic         s_tuser,   // kind
    input  logic         s_tlast,   // last_word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // estimate[31:0], total_increments[95:32]
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_wr_index,
    input  logic [3:0]   cfg_wr_data
);
    logic [3:0]  rows_reg, bits_reg;
    logic [31:0] len_reg;
    logic [63:0] total_reg;
    logic        busy_reg;       // word in hash pipe
    logic        last_reg, kind_reg;
    logic        mix_done, upd_busy, clearing, res_valid, upd_start;
    logic [31:0] res_est;
    logic [2:0]  nbytes;
    logic [MAX_ROWS-1:0][31:0] acc;
    logic        accept;
    logic        upd_busy_d, u_done;

    assign accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg && !upd_busy && !m_tvalid && !upd_start && !u_done;
    assign nbytes = (!s_tlast || s_tdata[34:32] >= 3'd4) ? 3'd4 : s_tdata[34:32];
    assign upd_start = mix_done && last_reg;

    cms_hash #(.MAX_ROWS(MAX_ROWS)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .mix_start(accept), .key_word(s_tdata[31:0]),
        .nbytes(nbytes), .restart(u_done),
        .mix_done(mix_done), .acc(acc)
    );

    cms_update #(.MAX_ROWS(MAX_ROWS), .MAX_BUCKET_BITS(MAX_BUCKET_BITS)) u_upd (
        .aclk(aclk), .aresetn(aresetn), .start(upd_start), .kind(kind_reg), .acc(acc),
        .key_len(len_reg), .rows_in_use(rows_reg), .bucket_bits(bits_reg),
        .busy(upd_busy), .clearing(clearing), .res_valid(res_valid), .res_estimate(res_est)
    );

    // hash accumulators and key length restart once the update unit is back in idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= 4'd4;
            bits_reg  <= 4'd12;
            len_reg   <= '0;
            total_reg <= '0;
            busy_reg  <= 1'b0;
            last_reg  <= 1'b0;
            kind_reg  <= 1'b0;
            m_tvalid  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_ROWS_IN_USE) rows_reg <= cfg_wr_data;
                else bits_reg <= cfg_wr_data;
            end
            if (accept) begin
                busy_reg <= 1'b1;
                last_reg <= s_tlast;
                kind_reg <= s_tuser;
                len_reg  <= len_reg + 32'(nbytes);
            end else if (mix_done) begin
                busy_reg <= 1'b0;
            end
            if (upd_start) begin
                last_reg <= 1'b0;
                if (kind_reg == KIND_INCREMENT) total_reg <= total_reg + 64'd1;
                else m_tdata[95:32] <= total_reg;
            end
            if (u_done) len_reg <= '0;
            if (res_valid) begin
                m_tvalid      <= 1'b1;
                m_tdata[31:0] <= res_est;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // key done: update unit returns to idle
    always_ff @(posedge aclk) begin
        if (!aresetn) upd_busy_d <= 1'b0;
        else          upd_busy_d <= upd_busy;
    end
    assign u_done = upd_busy_d && !upd_busy && !clearing;
endmodule

// ===== rtl/core/cms_checker.sv =====
// Port-level checker for the sketch core, bound to the top level.
module cms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("word taken back to back");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input open with result pending");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready) else $error("reset state");
endmodule

bind count_min_sketch_conservative_core cms_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== test/count_min_sketch_conservative_core_test.sv =====
// Self-checking testbench for the count-min sketch core with conservative update.
`timescale 1ns / 1ps

class sketch_scoreboard;
    logic [31:0] cells [8][4096];
    logic [31:0] row_acc [8];
    logic [31:0] key_len;
    logic [63:0] incr_count;
    logic [3:0]  rows_reg;
    logic [3:0]  bits_reg;
    logic [95:0] pending_q [$];
    int          n_errors;
    int          n_queries;
    int          n_increments;

    function new();
        for (int r = 0; r < 8; r++) begin
            for (int b = 0; b < 4096; b++) begin
                cells[r][b] = '0;
            end
        end
        restart();
        incr_count = '0;
        rows_reg   = 4'd4;
        bits_reg   = 4'd12;
        n_errors   = 0;
        n_queries  = 0;
        n_increments = 0;
    endfunction

    function void restart();
        for (int r = 0; r < 8; r++) begin
            row_acc[r] = r;
        end
        key_len = '0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [3:0] val);
        if (idx == cms_pkg::REG_ROWS_IN_USE) begin
            rows_reg = val;
        end else begin
            bits_reg = val;
        end
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function logic [31:0] mix_word(logic [31:0] k);
        logic [31:0] t;
        t = k * 32'hcc9e2d51;
        t = rol(t, 15);
        return t * 32'h1b873593;
    endfunction

    function logic [31:0] avalanche(logic [31:0] h, logic [31:0] len);
        h = h ^ len;
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        return h ^ (h >> 16);
    endfunction

    // Note an accepted request; queue an expected estimate for a query.
    function void note_request(logic kind, logic [31:0] word, logic [2:0] nb, logic last);
        int unsigned nbytes;
        int unsigned rows;
        int unsigned bits;
        logic [31:0] mask;
        logic [31:0] minv;
        logic [11:0] bucket [8];
        logic [31:0] h;
        nbytes = (!last || nb >= 4) ? 4 : nb;
        for (int r = 0; r < 8; r++) begin
            h = row_acc[r];
            if (nbytes == 4) begin
                h = h ^ mix_word(word);
                h = rol(h, 13);
                h = h * 32'd5 + 32'he6546b64;
            end else if (nbytes > 0) begin
                h = h ^ mix_word(word & ((32'd1 << (8 * nbytes)) - 1));
            end
            row_acc[r] = h;
        end
        key_len = key_len + nbytes;
        if (!last) return;
        rows = (rows_reg < 1) ? 1 : (rows_reg > 8) ? 8 : rows_reg;
        bits = (bits_reg > 12) ? 12 : bits_reg;
        mask = (32'd1 << bits) - 1;
        minv = 32'hffffffff;
        for (int r = 0; r < rows; r++) begin
            bucket[r] = 12'(avalanche(row_acc[r], key_len) & mask);
            if (cells[r][bucket[r]] < minv) minv = cells[r][bucket[r]];
        end
        restart();
        if (kind == cms_pkg::KIND_INCREMENT) begin
            incr_count = incr_count + 1;
            n_increments++;
            if (minv != 32'hffffffff) begin
                for (int r = 0; r < rows; r++) begin
                    if (cells[r][bucket[r]] == minv) cells[r][bucket[r]] = minv + 1;
                end
            end
        end else begin
            pending_q.push_back({incr_count, minv});
        end
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task check_result(logic [95:0] got);
        logic [95:0] want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        want = pending_q.pop_front();
        n_queries++;
        if (got[31:0] !== want[31:0])
            report($sformatf("estimate %h, expected %h", got[31:0], want[31:0]));
        if (got[95:32] !== want[95:32])
            report($sformatf("total %h, expected %h", got[95:32], want[95:32]));
    endtask
endclass

module count_min_sketch_conservative_core_test;
    import cms_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        cfg_wr_en;
    logic [0:0]  cfg_wr_index;
    logic [3:0]  cfg_wr_data;

    sketch_scoreboard sb;
    int  cycle_count;
    logic [31:0] hot_keys [8];

    count_min_sketch_conservative_core u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: clear sweep plus worst-case per-word and per-key cost, several times over.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 600000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, stretches with none.
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    task automatic send_word(logic kind, logic [31:0] word, logic [2:0] nb, logic last,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, nb, word};
        s_tuser  <= kind;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, word, nb, last);
    endtask

    // Whole key from a seed value; len in bytes, at least 1.
    task automatic send_key(logic kind, logic [31:0] seed, int len, bit fast = 0);
        int nwords;
        logic [31:0] w;
        nwords = (len + 3) / 4;
        for (int i = 0; i < nwords; i++) begin
            w = seed ^ (i * 32'h9e3779b9);
            send_word(kind, w, (i == nwords - 1) ? 3'(len - 4 * i) : 3'd4,
                      i == nwords - 1, fast);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        // an increment may still be updating the table
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        cfg_wr_en    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(int n_keys);
        int pick;
        int len;
        for (int k = 0; k < n_keys; k++) begin
            pick = $urandom_range(0, 9);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            if (pick < 7) begin
                // mostly hot keys so counters grow and collide
                send_key(1'($urandom_range(0, 1)), hot_keys[$urandom_range(0, 7)], len,
                         $urandom_range(0, 3) == 0);
            end else if (pick == 7) begin
                // odd byte counts: 0, 5..7 on the last word
                send_word(KIND_QUERY, $urandom, 3'd4, 1'b0);
                send_word(1'($urandom_range(0, 1)), $urandom,
                          ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7)), 1'b1);
            end else begin
                // fully random words, any word_bytes on non-last words
                send_word(1'($urandom_range(0, 1)), $urandom, 3'($urandom), 1'b0);
                send_word(1'($urandom_range(0, 1)), $urandom, 3'($urandom_range(1, 4)), 1'b1);
            end
        end
    endtask

    initial begin
        sb = new();
        for (int i = 0; i < 8; i++) hot_keys[i] = $urandom;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = '0;
        cfg_wr_data  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default config, extremes of fields
        send_key(KIND_QUERY, 32'h0, 4);
        send_key(KIND_INCREMENT, 32'h0, 4);
        send_key(KIND_INCREMENT, 32'h0, 4);
        send_key(KIND_QUERY, 32'h0, 4);
        send_key(KIND_INCREMENT, 32'hffffffff, 1);
        send_key(KIND_QUERY, 32'hffffffff, 1);
        send_key(KIND_INCREMENT, 32'ha5a5a5a5, 2);
        send_key(KIND_QUERY, 32'ha5a5a5a5, 3);
        send_key(KIND_INCREMENT, 32'h5a5a5a5a, 13);
        send_key(KIND_QUERY, 32'h5a5a5a5a, 13);
        send_word(KIND_INCREMENT, 32'h12345678, 3'd1, 1'b0);   // non-last short count ignored
        send_word(KIND_QUERY, 32'h0, 3'd0, 1'b1);              // empty tail
        send_word(KIND_QUERY, 32'hdeadbeef, 3'd7, 1'b1);       // count above 4
        send_word(KIND_QUERY, 32'h0, 3'd0, 1'b1);
        drain();
        // pause until nothing is outstanding, then continue

        random_phase(45);
        drain();

        // extremes: one row, one bucket (all keys collide)
        write_reg(REG_ROWS_IN_USE, 4'd1);
        write_reg(REG_BUCKET_BITS, 4'd0);
        send_key(KIND_INCREMENT, 32'h1, 4);
        send_key(KIND_QUERY, 32'h2, 5);
        random_phase(45);
        drain();

        // out of range: rows 0 and 15, bits 15
        write_reg(REG_ROWS_IN_USE, 4'd0);
        write_reg(REG_BUCKET_BITS, 4'd15);
        random_phase(35);
        drain();
        write_reg(REG_ROWS_IN_USE, 4'd15);
        write_reg(REG_BUCKET_BITS, 4'd2);
        random_phase(45);
        drain();

        write_reg(REG_ROWS_IN_USE, 4'd8);
        write_reg(REG_BUCKET_BITS, 4'd12);
        random_phase(45);
        drain();
        write_reg(REG_ROWS_IN_USE, 4'd3);
        write_reg(REG_BUCKET_BITS, 4'd1);
        random_phase(45);
        drain();

        repeat (50) @(posedge aclk);
        $display("Covered %0d increments and %0d checked queries over six register settings,",
                 sb.n_increments, sb.n_queries);
        $display("including one row/one bucket collisions and out-of-range register values.");
        if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (sb.pending_q.size() != 0)
                $display("%0d expected results never arrived", sb.pending_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/cms_pkg.sv
rtl/core/cms_ram.sv
rtl/core/cms_hash.sv
rtl/core/cms_update.sv
rtl/core/count_min_sketch_conservative_core.sv
rtl/core/cms_checker.sv
test/count_min_sketch_conservative_core_test.sv
